// ===== rtl/zph_pkg.sv =====
// zph_pkg: shared constants and types of the zobrist position hash unit
// key numbering, splitmix64 constants and the key job word passed front to back
// no dependencies
package zph_pkg;

    localparam int SQUARES     = 64;
    localparam int PIECE_CODES = 16;

    localparam logic [63:0] KEY_SEED  = 64'h6a09e667f3bcc909;
    localparam logic [63:0] KEY_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

    localparam int MIX_SHIFT_A   = 30;
    localparam int MIX_SHIFT_B   = 27;
    localparam int MIX_SHIFT_OUT = 31;

    // key numbers run up to the side-to-move key
    localparam int KEY_NUM_W = 11;
    localparam logic [KEY_NUM_W-1:0] CASTLE_BASE  = KEY_NUM_W'(PIECE_CODES * SQUARES);
    localparam logic [KEY_NUM_W-1:0] EP_BASE      = KEY_NUM_W'(PIECE_CODES * SQUARES + 16);
    localparam logic [KEY_NUM_W-1:0] SIDE_KEY_NUM =
        KEY_NUM_W'(PIECE_CODES * SQUARES + 16 + SQUARES);

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    // one key to generate and fold in; emit marks the final key of a position
    typedef struct packed {
        logic [KEY_NUM_W-1:0] key_num;
        logic                 emit;
    } zph_job_t;

endpackage

// ===== rtl/zph_front.sv =====
// zph_front: accepts square words, holds the empty code and splits each word
// into key jobs (piece, castling, en passant, side to move)
// depends on zph_pkg
module zph_front import zph_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    output zph_job_t              job,
    output logic                  job_valid,
    input  logic                  job_ready
);

    logic [3:0] empty_code_reg;
    logic [3:0] pend_reg, pend_next;
    logic       last_reg, last_next;
    logic [9:0] piece_sq_reg;
    logic [3:0] castling_reg;
    logic [5:0] ep_sq_reg;
    logic       accept;
    logic [3:0] new_mask;
    logic [3:0] sel;

    assign s_axis_tready = (pend_reg == 4'b0000);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // bit 0 piece key, bit 1 castling, bit 2 en passant, bit 3 side to move
    always_comb begin
        new_mask[0] = (s_axis_tdata[3:0] != empty_code_reg);
        new_mask[1] = s_axis_tlast;
        new_mask[2] = s_axis_tlast && s_axis_tdata[14];
        new_mask[3] = s_axis_tlast && s_axis_tdata[21];
    end

    assign sel       = pend_reg & 4'(~pend_reg + 4'd1);
    assign job_valid = (pend_reg != 4'b0000);

    always_comb begin
        case (sel)
            4'b0001: job.key_num = {1'b0, piece_sq_reg};
            4'b0010: job.key_num = CASTLE_BASE + {7'b0, castling_reg};
            4'b0100: job.key_num = EP_BASE + {5'b0, ep_sq_reg};
            default: job.key_num = SIDE_KEY_NUM;
        endcase
        job.emit = last_reg && ((pend_reg & ~sel) == 4'b0000);
    end

    always_comb begin
        pend_next = pend_reg;
        last_next = last_reg;
        if (accept) begin
            pend_next = new_mask;
            last_next = s_axis_tlast;
        end else if (job_valid && job_ready) begin
            pend_next = pend_reg & ~sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_code_reg <= 4'd0;
            pend_reg       <= 4'b0000;
            last_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                empty_code_reg <= cfg_wdata;
            end
            pend_reg <= pend_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            piece_sq_reg <= {s_axis_tdata[3:0], s_axis_tdata[9:4]};
            castling_reg <= s_axis_tdata[13:10];
            ep_sq_reg    <= s_axis_tdata[20:15];
        end
    end

endmodule

// ===== rtl/zph_queue.sv =====
// zph_queue: short job queue between the front and the key generator
// depends on zph_pkg
module zph_queue import zph_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  zph_job_t push_job,
    input  logic     push_valid,
    output logic     push_ready,
    output zph_job_t pop_job,
    output logic     pop_valid,
    input  logic     pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    zph_job_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/zph_back.sv =====
// zph_back: splitmix64 key generator on one shared 32x32 multiplier,
// the hash accumulator and the output register
// depends on zph_pkg
module zph_back import zph_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  zph_job_t               job,
    input  logic                   job_valid,
    output logic                   job_ready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [1:0]  stage_reg, stage_next;
    logic [1:0]  step_reg, step_next;
    logic        emit_reg, emit_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [63:0] mix_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] addend;
    logic [63:0] key;

    assign job_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_comb begin
        case (stage_reg)
            2'd0:    mix_const = KEY_GAMMA;
            2'd1:    mix_const = MIX_MUL_A;
            default: mix_const = MIX_MUL_B;
        endcase
    end

    // low 64 bits of x * c from three partial products, one per cycle
    assign mul_a  = (step_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b  = (step_reg == 2'd1) ? mix_const[63:32] : mix_const[31:0];
    assign addend = (step_reg == 2'd1) ? prod_reg : {prod_reg[31:0], 32'b0};
    assign key    = z_reg ^ (z_reg >> MIX_SHIFT_OUT);

    always_comb begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        step_next      = step_reg;
        emit_next      = emit_reg;
        x_next         = x_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    x_next     = 64'(job.key_num) + 64'd1;
                    z_next     = KEY_SEED;
                    stage_next = 2'd0;
                    step_next  = 2'd0;
                    emit_next  = job.emit;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next = mul_a * mul_b;
                if (step_reg != 2'd0) begin
                    z_next = z_reg + addend;
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = (stage_reg == 2'd2) ? ST_DONE : ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (stage_reg == 2'd0) begin
                    x_next = z_reg ^ (z_reg >> MIX_SHIFT_A);
                end else begin
                    x_next = z_reg ^ (z_reg >> MIX_SHIFT_B);
                end
                z_next     = 64'd0;
                step_next  = 2'd0;
                stage_next = stage_reg + 2'd1;
                state_next = ST_MUL;
            end
            ST_DONE: begin
                if (!emit_reg) begin
                    acc_next   = acc_reg ^ key;
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || m_axis_tready) begin
                    out_next       = acc_reg ^ key;
                    out_valid_next = 1'b1;
                    acc_next       = 64'd0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stage_reg     <= 2'd0;
            step_reg      <= 2'd0;
            emit_reg      <= 1'b0;
            acc_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            step_reg      <= step_next;
            emit_reg      <= emit_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

endmodule

// ===== rtl/zobrist_position_hash_unit.sv =====
// Zobrist position hash unit. Squares stream in one word each; an occupied square
// (piece code other than the programmed empty code) folds the splitmix64 key for
// its piece and square into a 64-bit hash, and the word marked tlast also folds in
// the castling key, the en passant key when valid and the side-to-move key when
// black is to move, then returns the hash as one output word and clears it for
// the next position. Keys are generated on the fly by one shared 32x32 multiplier:
// each key takes three 64-bit mix multiplies of three partial products each, plus
// load and finish steps, and the back end takes no new key until it has finished
// the last one. The front end takes no new square until it has queued every key
// job of the last one; with the job queue (QUEUE_DEPTH entries) full it waits for
// the back end. The user must write empty_code through cfg_we/cfg_wdata only
// while no position is in flight; the block itself does not enforce this.
// depends on zph_pkg, zph_front, zph_queue, zph_back
module zobrist_position_hash_unit import zph_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [3:0]             cfg_wdata,     // empty_code
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // piece_code[3:0], square_index[9:4], castle_bits[13:10], ep_valid[14],
    // ep_square[20:15], black_to_move[21], zero[23:22]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,  // last_square
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // position_key[63:0]
);

    zph_job_t front_job;
    logic     front_valid;
    logic     front_ready;
    zph_job_t back_job;
    logic     back_valid;
    logic     back_ready;

    zph_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .job           (front_job),
        .job_valid     (front_valid),
        .job_ready     (front_ready)
    );

    zph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (back_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    zph_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job           (back_job),
        .job_valid     (back_valid),
        .job_ready     (back_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
